// File: design/wls_pkg.sv
// Package for the windowed latency statistics block.
// Holds the sequencer state type and the fixed field widths and constants.
// No dependencies.
package wls_pkg;

    localparam int LAT_W  = 20;
    localparam int STAT_W = 21;
    localparam int PCT_W  = 7;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 80;

    localparam logic [STAT_W-1:0] LOSS_MARK  = {STAT_W{1'b1}};
    localparam logic [LAT_W-1:0]  LAT_MAX    = {LAT_W{1'b1}};
    localparam logic [PCT_W-1:0]  LOSS_SCALE = 7'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_EVICT,
        ST_INSERT,
        ST_SCAN,
        ST_MEAN_WAIT,
        ST_LOSS_WAIT
    } wls_state_t;

endpackage

// File: design/windowed_latency_stats_top.sv
// Windowed latency statistics: top level with sequencer, sample RAM and shared divider.
// Depends on wls_pkg, wls_ram and wls_serial_div.
// Per accepted sample: evict the oldest entry when full, insert the new one, then scan the RAM
// for min and max; the RAM scan overlaps the mean divide, the loss divide follows.
// One word at a time: input is not ready while a word is in work, output stalls included.
// Reset clears counters, pointer and sequencer; the sample RAM is not cleared.
module windowed_latency_stats_top #(
    parameter int WINDOW = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [wls_pkg::IN_W-1:0]   s_axis_tdata,  // latency_us[19:0], zero pad
    input  logic [0:0]                 s_axis_tuser,  // lost
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [wls_pkg::OUT_W-1:0]  m_axis_tdata   // mean_us, min_us, max_us,
                                                      // loss_percent, sample_count, pad
);

    localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int SUM_W = wls_pkg::LAT_W + CW;
    localparam int NUM_W = wls_pkg::PCT_W + CW;

    wls_pkg::wls_state_t state_reg, state_next;

    logic [PW-1:0]                 wp_reg, wp_next;
    logic [CW-1:0]                 held_reg, held_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [CW-1:0]                 mcount_reg, mcount_next;
    logic [CW-1:0]                 lcount_reg, lcount_next;
    logic [CW-1:0]                 scan_idx_reg, scan_idx_next;
    logic                          rd_pend_reg, rd_pend_next;
    logic                          have_reg, have_next;
    logic [wls_pkg::LAT_W-1:0]     min_reg, min_next;
    logic [wls_pkg::LAT_W-1:0]     max_reg, max_next;
    logic [wls_pkg::LAT_W-1:0]     mean_reg, mean_next;
    logic                          lost_in_reg, lost_in_next;
    logic [wls_pkg::LAT_W-1:0]     lat_in_reg, lat_in_next;
    logic                          m_valid_reg, m_valid_next;
    logic [wls_pkg::OUT_W-1:0]     m_data_reg, m_data_next;

    logic                          ram_we;
    logic [PW-1:0]                 ram_raddr;
    logic [wls_pkg::STAT_W-1:0]    ram_wdata;
    logic [wls_pkg::STAT_W-1:0]    ram_rdata;

    logic                          div_start;
    logic [SUM_W-1:0]              div_dividend;
    logic [CW-1:0]                 div_divisor;
    logic                          div_busy;
    logic [SUM_W-1:0]              div_quo;

    logic                          full;
    logic [NUM_W-1:0]              loss_num;
    logic [wls_pkg::LAT_W-1:0]     rd_lat;
    logic [wls_pkg::STAT_W-1:0]    mean_f, min_f, max_f;

    wls_ram #(
        .WIDTH (wls_pkg::STAT_W),
        .DEPTH (WINDOW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wls_serial_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign full     = (held_reg == CW'(WINDOW));
    assign loss_num = NUM_W'(lcount_reg) * NUM_W'(wls_pkg::LOSS_SCALE);
    assign rd_lat   = ram_rdata[wls_pkg::LAT_W-1:0];
    assign mean_f   = (mcount_reg == '0) ? wls_pkg::LOSS_MARK : {1'b0, mean_reg};
    assign min_f    = have_reg ? {1'b0, min_reg} : wls_pkg::LOSS_MARK;
    assign max_f    = have_reg ? {1'b0, max_reg} : wls_pkg::LOSS_MARK;

    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        held_next     = held_reg;
        sum_next      = sum_reg;
        mcount_next   = mcount_reg;
        lcount_next   = lcount_reg;
        scan_idx_next = scan_idx_reg;
        rd_pend_next  = rd_pend_reg;
        have_next     = have_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        mean_next     = mean_reg;
        lost_in_next  = lost_in_reg;
        lat_in_next   = lat_in_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_raddr     = wp_reg;
        ram_wdata     = lost_in_reg ? wls_pkg::LOSS_MARK : {1'b0, lat_in_reg};
        div_start     = 1'b0;
        div_dividend  = sum_reg;
        div_divisor   = mcount_reg;
        s_axis_tready = (state_reg == wls_pkg::ST_IDLE);

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            wls_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    lost_in_next = s_axis_tuser[0];
                    lat_in_next  = s_axis_tdata[wls_pkg::LAT_W-1:0];
                    state_next   = wls_pkg::ST_EVICT_RD;
                end
            end
            wls_pkg::ST_EVICT_RD: begin
                state_next = wls_pkg::ST_EVICT;
            end
            wls_pkg::ST_EVICT: begin
                if (full) begin
                    if (ram_rdata == wls_pkg::LOSS_MARK) begin
                        if (lcount_reg != '0) lcount_next = lcount_reg - CW'(1);
                    end else begin
                        if (mcount_reg != '0) mcount_next = mcount_reg - CW'(1);
                        if (sum_reg >= SUM_W'(rd_lat)) begin
                            sum_next = sum_reg - SUM_W'(rd_lat);
                        end else begin
                            sum_next = '0;
                        end
                    end
                end
                state_next = wls_pkg::ST_INSERT;
            end
            wls_pkg::ST_INSERT: begin
                ram_we = 1'b1;
                if (lost_in_reg) begin
                    lcount_next = lcount_reg + CW'(1);
                end else begin
                    mcount_next = mcount_reg + CW'(1);
                    sum_next    = sum_reg + SUM_W'(lat_in_reg);
                end
                if (!full) held_next = held_reg + CW'(1);
                wp_next       = (wp_reg == PW'(WINDOW - 1)) ? '0 : wp_reg + PW'(1);
                scan_idx_next = '0;
                rd_pend_next  = 1'b0;
                have_next     = 1'b0;
                state_next    = wls_pkg::ST_SCAN;
            end
            wls_pkg::ST_SCAN: begin
                if (scan_idx_reg == '0 && !rd_pend_reg) begin
                    div_start = 1'b1;
                end
                if (rd_pend_reg && ram_rdata != wls_pkg::LOSS_MARK) begin
                    if (!have_reg || rd_lat < min_reg) min_next = rd_lat;
                    if (!have_reg || rd_lat > max_reg) max_next = rd_lat;
                    have_next = 1'b1;
                end
                if (scan_idx_reg < held_reg) begin
                    ram_raddr     = scan_idx_reg[PW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                    rd_pend_next  = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg) state_next = wls_pkg::ST_MEAN_WAIT;
                end
            end
            wls_pkg::ST_MEAN_WAIT: begin
                if (!div_busy) begin
                    if (div_quo > SUM_W'(wls_pkg::LAT_MAX)) begin
                        mean_next = wls_pkg::LAT_MAX;
                    end else begin
                        mean_next = div_quo[wls_pkg::LAT_W-1:0];
                    end
                    div_start    = 1'b1;
                    div_dividend = SUM_W'(loss_num);
                    div_divisor  = held_reg;
                    state_next   = wls_pkg::ST_LOSS_WAIT;
                end
            end
            wls_pkg::ST_LOSS_WAIT: begin
                if (!div_busy && (!m_valid_reg || m_axis_tready)) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000,
                                    wls_pkg::PCT_W'(held_reg),
                                    wls_pkg::PCT_W'(div_quo),
                                    max_f, min_f, mean_f};
                    state_next   = wls_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wls_pkg::ST_IDLE;
            wp_reg       <= '0;
            held_reg     <= '0;
            sum_reg      <= '0;
            mcount_reg   <= '0;
            lcount_reg   <= '0;
            scan_idx_reg <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            held_reg     <= held_next;
            sum_reg      <= sum_next;
            mcount_reg   <= mcount_next;
            lcount_reg   <= lcount_next;
            scan_idx_reg <= scan_idx_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        have_reg    <= have_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        mean_reg    <= mean_next;
        lost_in_reg <= lost_in_next;
        lat_in_reg  <= lat_in_next;
        m_data_reg  <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CW'(WINDOW))
        else $error("held count above window");

    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wls_pkg::ST_IDLE |->
            ({1'b0, mcount_reg} + {1'b0, lcount_reg}) == {1'b0, held_reg})
        else $error("measured and lost counts disagree with held count");

    a_wp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= PW'(WINDOW - 1))
        else $error("write pointer out of range");

    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> div_busy)
        else $error("divider did not start");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while word in work");

endmodule

// File: design/wls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wls_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/wls_serial_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies; shared by the mean and loss computations of the top level.
module wls_serial_div #(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DIVISOR_W]) begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
